>>> hdl/spq_pkg.sv
// Package for the sorted priority queue: item types, codes and defaults.
// Used by spq_cell, sorted_priority_queue_unit and spq_checker.
package spq_pkg;

    // Field widths fixed by the item format.
    localparam int TAG_W    = 16;
    localparam int SCORE_W  = 32;
    localparam int OCC_W    = 5;

    // Default sizes for the queue.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;

    // Operation carried by an input item.
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_cmd;

    // Outcome reported with each result item.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [TAG_W-1:0]   node_tag;
        logic [SCORE_W-1:0] score;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]   popped_tag;
        logic [SCORE_W-1:0] popped_score;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
    } t_out_item;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_op;

endpackage

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds a score and a tag, compares against
// the broadcast score and takes data from its left or right neighbor.
// Depends on spq_pkg.
module spq_cell #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  spq_pkg::t_cell_op           i_op,
    input  logic                        i_occ,
    input  logic [spq_pkg::SCORE_W-1:0] i_new_score,
    input  logic [TAG_BITS-1:0]         i_new_tag,
    input  logic                        i_left_le,
    input  logic [spq_pkg::SCORE_W-1:0] i_left_score,
    input  logic [TAG_BITS-1:0]         i_left_tag,
    input  logic [spq_pkg::SCORE_W-1:0] i_right_score,
    input  logic [TAG_BITS-1:0]         i_right_tag,
    output logic                        o_le,
    output logic [spq_pkg::SCORE_W-1:0] o_score,
    output logic [TAG_BITS-1:0]         o_tag
);

    logic [spq_pkg::SCORE_W-1:0] r_score, n_score;
    logic [TAG_BITS-1:0]         r_tag, n_tag;

    // An occupied slot whose score does not exceed the new one stays put.
    assign o_le = i_occ && (r_score <= i_new_score);

    // On insert the first slot past the stay-put prefix takes the new entry,
    // and the slots after it move one place right. On pop all move left.
    always_comb begin
        n_score = r_score;
        n_tag   = r_tag;
        if (i_op.insert && !o_le) begin
            if (i_left_le) begin
                n_score = i_new_score;
                n_tag   = i_new_tag;
            end else begin
                n_score = i_left_score;
                n_tag   = i_left_tag;
            end
        end else if (i_op.pop) begin
            n_score = i_right_score;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_score = r_score;
    assign o_tag   = r_tag;

endmodule

>>> hdl/sorted_priority_queue_unit.sv
// Sorted min-priority queue. The block takes one insert or pop item per cycle
// for as long as results are taken; the limit is the compare-and-shift across
// the chain of cells, where every slot compares its score with the new one in
// parallel and moves its entry one place left or right. Each item gives one
// result from an output register, and a new item is accepted while the
// previous result waits unless the output is stalled. Entries with equal
// scores leave in the order they came. There is no clearing pass after reset.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TEXT_W = TAG_BITS + spq_pkg::TAG_W;
    localparam int OEXT_W = CNT_W + spq_pkg::OCC_W;

    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    spq_pkg::t_out_item       r_out_item, n_out_item;
    logic                     w_accept, w_full, w_empty;
    spq_pkg::t_cell_op        w_op;
    logic [TEXT_W-1:0]        w_in_tag_ext, w_out_tag_ext;
    logic [OEXT_W-1:0]        w_occ_ext;
    logic [TAG_BITS-1:0]      w_new_tag;

    logic                        w_le    [QUEUE_DEPTH];
    logic [spq_pkg::SCORE_W-1:0] w_score [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]         w_tag   [QUEUE_DEPTH];

    // Input is held back only while a result waits and the output is stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    assign w_op.insert = w_accept && (i_in_item.cmd == spq_pkg::CMD_INSERT) && !w_full;
    assign w_op.pop    = w_accept && (i_in_item.cmd == spq_pkg::CMD_POP) && !w_empty;

    // Stored tags keep TAG_BITS bits of the incoming tag.
    assign w_in_tag_ext = {{TAG_BITS{1'b0}}, i_in_item.node_tag};
    assign w_new_tag    = w_in_tag_ext[TAG_BITS-1:0];

    // Chain of cells; the last one feeds itself on pop since it is vacated.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                        w_left_le;
        logic [spq_pkg::SCORE_W-1:0] w_left_score, w_right_score;
        logic [TAG_BITS-1:0]         w_left_tag, w_right_tag;

        if (g == 0) begin : g_first
            assign w_left_le    = 1'b1;
            assign w_left_score = w_score[g];
            assign w_left_tag   = w_tag[g];
        end else begin : g_mid
            assign w_left_le    = w_le[g-1];
            assign w_left_score = w_score[g-1];
            assign w_left_tag   = w_tag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right_score = w_score[g];
            assign w_right_tag   = w_tag[g];
        end else begin : g_inner
            assign w_right_score = w_score[g+1];
            assign w_right_tag   = w_tag[g+1];
        end

        spq_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_occ        (r_count > CNT_W'(g)),
            .i_new_score  (i_in_item.score),
            .i_new_tag    (w_new_tag),
            .i_left_le    (w_left_le),
            .i_left_score (w_left_score),
            .i_left_tag   (w_left_tag),
            .i_right_score(w_right_score),
            .i_right_tag  (w_right_tag),
            .o_le         (w_le[g]),
            .o_score      (w_score[g]),
            .o_tag        (w_tag[g])
        );
    end

    // Entry count after this item.
    always_comb begin
        n_count = r_count;
        if (w_op.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result of this item; the popped entry is the head of the chain.
    assign w_out_tag_ext = {{spq_pkg::TAG_W{1'b0}}, w_tag[0]};
    assign w_occ_ext     = {{spq_pkg::OCC_W{1'b0}}, n_count};

    always_comb begin
        n_out_item              = '0;
        n_out_item.status       = spq_pkg::ST_DONE;
        n_out_item.occupancy    = w_occ_ext[spq_pkg::OCC_W-1:0];
        unique case (i_in_item.cmd)
            spq_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_out_item.status = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::CMD_POP: begin
                if (w_empty) begin
                    n_out_item.status = spq_pkg::ST_EMPTY;
                end else begin
                    n_out_item.popped_tag   = w_out_tag_ext[spq_pkg::TAG_W-1:0];
                    n_out_item.popped_score = w_score[0];
                end
            end
            default: begin
                n_out_item.status = spq_pkg::ST_DONE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/spq_checker.sv
// Port-level checks for sorted_priority_queue_unit and the bind that
// attaches them. Depends on spq_pkg.
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input spq_pkg::t_out_item o_out_item
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every accepted item has its result ready in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item gave no result");

    // Input is never held back while no result is waiting.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

>>> tb/spq_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority queue. It watches both item channels, keeps
// its own copy of the queue and compares every result item with its prediction.
// Depends on spq_pkg.
module tb_spq_checker #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  spq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  spq_pkg::t_out_item i_out_item,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending_count
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the queue, kept in ascending score order.
    logic [spq_pkg::SCORE_W-1:0] held_score [QUEUE_DEPTH];
    logic [spq_pkg::TAG_W-1:0]   held_tag   [QUEUE_DEPTH];
    int unsigned                 held_count = 0;

    // Results still owed by the block, oldest first.
    spq_pkg::t_out_item          owed_results [$];
    int unsigned                 fail_count = 0;

    assign o_fail_count = fail_count;

    // Apply one operation to the shadow queue and return the result it gives.
    function automatic spq_pkg::t_out_item apply_queue_op(input spq_pkg::t_in_item item);
        spq_pkg::t_out_item res;
        int unsigned        pos;
        int unsigned        i;
        res        = '0;
        res.status = spq_pkg::ST_DONE;
        if (item.cmd == spq_pkg::CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // The new entry goes behind every entry with a lower or equal score.
                pos = 0;
                while (pos < held_count && held_score[pos] <= item.score) begin
                    pos++;
                end
                for (i = held_count; i > pos; i--) begin
                    held_score[i] = held_score[i-1];
                    held_tag[i]   = held_tag[i-1];
                end
                held_score[pos] = item.score;
                held_tag[pos]   = item.node_tag;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            // Take the front entry and close the gap.
            res.popped_tag   = held_tag[0];
            res.popped_score = held_score[0];
            for (i = 1; i < held_count; i++) begin
                held_score[i-1] = held_score[i];
                held_tag[i-1]   = held_tag[i];
            end
            held_count--;
        end
        res.occupancy = spq_pkg::OCC_W'(held_count);
        return res;
    endfunction

    // Predict on each accepted input item, compare on each accepted result item.
    always @(posedge i_clk) begin
        spq_pkg::t_out_item owed;
        spq_pkg::t_out_item predicted;
        if (!i_rst_n) begin
            held_count = 0;
            owed_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predicted    = apply_queue_op(i_in_item);
                owed_results = {owed_results, predicted};
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected result: tag %h score %h status %0d occ %0d",
                                 $realtime, i_out_item.popped_tag, i_out_item.popped_score,
                                 i_out_item.status, i_out_item.occupancy);
                    end
                    fail_count++;
                end else begin
                    owed = owed_results.pop_front();
                    if (i_out_item.popped_tag !== owed.popped_tag ||
                            i_out_item.popped_score !== owed.popped_score ||
                            i_out_item.status !== owed.status ||
                            i_out_item.occupancy !== owed.occupancy) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display("%0t: expected tag %h score %h status %0d occ %0d",
                                     $realtime, owed.popped_tag, owed.popped_score,
                                     owed.status, owed.occupancy);
                            $display("%0t: actual   tag %h score %h status %0d occ %0d",
                                     $realtime, i_out_item.popped_tag, i_out_item.popped_score,
                                     i_out_item.status, i_out_item.occupancy);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_pending_count = owed_results.size();
    end

endmodule

>>> tb/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 100ps
// Testbench top for sorted_priority_queue_unit: directed and random insert and
// pop items under changing idle patterns. Depends on spq_pkg, the block and tb_spq_checker.
module tb_sorted_priority_queue_unit;

    localparam int RANDOM_ITEMS = 1625;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    spq_pkg::t_in_item  in_item   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    spq_pkg::t_out_item out_item;

    int unsigned send_idle_pct = 9;
    int unsigned take_idle_pct = 65;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned pending_count;

    // Scores for the opening fill: extremes, ties at both ends and in the middle.
    logic [spq_pkg::SCORE_W-1:0] fill_scores [16] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005,
        32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0006, 32'h0001_0000, 32'hAAAA_5555
    };

    sorted_priority_queue_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    tb_spq_checker #(
        .QUEUE_DEPTH (spq_pkg::QUEUE_DEPTH_DEF)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The result side stalls at random at the current rate.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < take_idle_pct);
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one item, with a random gap first, and return once it is accepted.
    // Called and returns at a falling edge; valid stays high for a following item.
    task automatic send_queue_item(input spq_pkg::t_in_item item);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) begin
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Build one random item; bursts lean toward inserts or pops to hit full and empty.
    function automatic spq_pkg::t_in_item random_queue_item(input int unsigned insert_pct);
        spq_pkg::t_in_item item;
        item.cmd      = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                          : spq_pkg::CMD_POP;
        item.node_tag = spq_pkg::TAG_W'($urandom);
        case ($urandom_range(4))
            0: item.score = spq_pkg::SCORE_W'($urandom_range(7));
            1: item.score = 32'hFFFF_FFF8 | spq_pkg::SCORE_W'($urandom_range(7));
            2: item.score = $urandom_range(1) ? '1 : '0;
            default: item.score = spq_pkg::SCORE_W'($urandom);
        endcase
        return item;
    endfunction

    // Stimulus and verdict.
    initial begin
        spq_pkg::t_in_item item;
        int unsigned       i;
        int unsigned       phase;
        int unsigned       burst_left;
        int unsigned       insert_pct;

        burst_left = 0;
        insert_pct = 50;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pop while empty, fill to the top, insert while full, then drain some.
        item = '0;
        item.cmd = spq_pkg::CMD_POP;
        send_queue_item(item);
        for (i = 0; i < 16; i++) begin
            item.cmd      = spq_pkg::CMD_INSERT;
            item.node_tag = spq_pkg::TAG_W'(i * 16'h1111);
            item.score    = fill_scores[i];
            send_queue_item(item);
        end
        item.cmd      = spq_pkg::CMD_INSERT;
        item.node_tag = 16'h1234;
        item.score    = '0;
        send_queue_item(item);
        for (i = 0; i < 7; i++) begin
            item.cmd      = spq_pkg::CMD_POP;
            item.node_tag = spq_pkg::TAG_W'($urandom);
            item.score    = spq_pkg::SCORE_W'($urandom);
            send_queue_item(item);
        end

        // Random part in three idle phases.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 9;
                    take_idle_pct = 65;
                end
                1: begin
                    send_idle_pct = 65;
                    take_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(40, 8);
                    case ($urandom_range(2))
                        0: insert_pct = 80;
                        1: insert_pct = 25;
                        default: insert_pct = 50;
                    endcase
                end
                burst_left--;
                send_queue_item(random_queue_item(insert_pct));
            end
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then keep watching for stray results.
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
hdl/spq_checker.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue_unit.sv
